>>> rtl/dqd_pkg.sv
// Shared types and constants for the double-ended queue with contents dump.
`timescale 1ns / 1ps

package dqd_pkg;

	localparam int DQ_DEPTH = 32;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 2;

	// Operation codes carried by the op field of an input word.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_APPEND     = 2'd1,
		OP_POP        = 2'd2
	} dq_op_t;

	// What every cell of the chain does at a clock edge.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_APPEND,
		CELL_SHIFT,
		CELL_ROTATE
	} cell_op_t;

	// Command broadcast from the controller to the whole chain.
	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  data;
	} cell_cmd_t;

endpackage

>>> rtl/dqd_cell.sv
// One storage cell of the queue chain: holds a single entry and trades it with its neighbors.
`timescale 1ns / 1ps

module dqd_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 5
) (
	input  logic                              clk,
	input  dqd_pkg::cell_cmd_t                cmd,
	input  logic [IDX_W-1:0]                  sel_idx,
	input  logic signed [dqd_pkg::DATA_W-1:0] prev_val,
	input  logic signed [dqd_pkg::DATA_W-1:0] next_val,
	input  logic signed [dqd_pkg::DATA_W-1:0] head_val,
	output logic signed [dqd_pkg::DATA_W-1:0] val
);
	import dqd_pkg::*;

	logic signed [DATA_W-1:0] val_q;
	logic                     is_sel;
	logic                     is_head;

	assign is_sel  = (sel_idx == IDX_W'(INDEX));
	assign is_head = (INDEX == 0);
	assign val     = val_q;

	// The entry moves toward the back on a push, toward the front on a pop, and
	// the selected tail cell takes the new word on an append or the head word on a rotate.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_PUSH: begin
				val_q <= is_head ? cmd.data : prev_val;
			end
			CELL_APPEND: begin
				if (is_sel) begin
					val_q <= cmd.data;
				end
			end
			CELL_SHIFT: begin
				val_q <= next_val;
			end
			CELL_ROTATE: begin
				val_q <= is_sel ? head_val : next_val;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

>>> rtl/dqd_ctrl.sv
// Controller of the queue: applies operations to the cell chain and sequences the dump.
`timescale 1ns / 1ps

module dqd_ctrl #(
	parameter int DEPTH = dqd_pkg::DQ_DEPTH,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [dqd_pkg::OP_W-1:0]          op,
	input  logic signed [dqd_pkg::DATA_W-1:0] value,
	input  logic signed [dqd_pkg::DATA_W-1:0] head_val,
	output logic                              busy,
	output dqd_pkg::cell_cmd_t                cmd,
	output logic [IDX_W-1:0]                  sel_idx,
	output logic                              strobe,
	output logic                              is_empty,
	output logic signed [dqd_pkg::DATA_W-1:0] entry_value,
	output logic                              last,
	output logic                              overflow
);
	import dqd_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     dropped_q;
	logic                     strobe_q;
	logic                     is_empty_q;
	logic                     last_q;
	logic                     overflow_q;
	logic signed [DATA_W-1:0] entry_q;

	logic                     accept;
	logic                     full;
	logic                     nonempty;
	logic                     drop;
	logic [CNT_W-1:0]         count_nxt;
	logic [CNT_W-1:0]         tail_pos;

	assign accept   = start && (state_q == ST_IDLE);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign tail_pos = count_q - CNT_W'(1);
	assign busy     = (state_q != ST_IDLE);

	// Decode the operation into a chain command and the count that follows it.
	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.data  = value;
		sel_idx   = count_q[IDX_W-1:0];
		count_nxt = count_q;
		drop      = 1'b0;
		if (accept) begin
			case (op)
				OP_PUSH_FRONT: begin
					if (full) begin
						drop = 1'b1;
					end else begin
						cmd.op    = CELL_PUSH;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				OP_APPEND: begin
					if (full) begin
						drop = 1'b1;
					end else begin
						cmd.op    = CELL_APPEND;
						count_nxt = count_q + CNT_W'(1);
					end
				end
				OP_POP: begin
					if (nonempty) begin
						cmd.op    = CELL_SHIFT;
						count_nxt = count_q - CNT_W'(1);
					end
				end
				default: begin
					cmd.op = CELL_HOLD;
				end
			endcase
		end else if (state_q == ST_DUMP && nonempty) begin
			cmd.op  = CELL_ROTATE;
			sel_idx = tail_pos[IDX_W-1:0];
		end
	end

	// State, count and registered result word. The dump rotates the chain once
	// around the stored entries, so the contents end where they started.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rem_q      <= '0;
			dropped_q  <= 1'b0;
			strobe_q   <= 1'b0;
			is_empty_q <= 1'b0;
			last_q     <= 1'b0;
			overflow_q <= 1'b0;
			entry_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q   <= count_nxt;
						rem_q     <= count_nxt;
						dropped_q <= drop;
						state_q   <= ST_DUMP;
					end
				end
				ST_DUMP: begin
					strobe_q   <= 1'b1;
					overflow_q <= dropped_q;
					if (!nonempty) begin
						is_empty_q <= 1'b1;
						entry_q    <= '0;
						last_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						is_empty_q <= 1'b0;
						entry_q    <= head_val;
						last_q     <= (rem_q == CNT_W'(1));
						rem_q      <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign is_empty    = is_empty_q;
	assign entry_value = entry_q;
	assign last        = last_q;
	assign overflow    = overflow_q;

endmodule

>>> rtl/deque_with_contents_dump.sv
// Top level of the double-ended queue with contents dump: cell chain plus controller.
`timescale 1ns / 1ps

// Usage:
// A command word (op, value) is taken at a rising edge where start is high and
// busy is low. op selects push at the front, append at the back or pop from the
// front; a pop on an empty queue and the unused code change nothing. An insert
// into a full queue is dropped and every result word of its dump has overflow set.
// After each command the queue contents are sent front to back, one result word
// per entry, each shown for one cycle with strobe high; the final word has last
// set. An empty queue sends one word with is_empty and last set.
// Timing: the command is applied at the edge that takes it; the controller then
// enters its dump state, which registers the result words from the head cell,
// one word per cycle, as it rotates the cell chain one position per cycle through
// its head cell. busy drops in the cycle that shows the last word, so the next
// command may be taken at the edge that ends that cycle.
// The receiver cannot stall; result words are not held.
// Reset empties the queue and clears busy and strobe; stored values are not cleared.
module deque_with_contents_dump #(
	parameter int DEPTH = dqd_pkg::DQ_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [dqd_pkg::OP_W-1:0]          op,
	input  logic signed [dqd_pkg::DATA_W-1:0] value,
	output logic                              strobe,
	output logic                              is_empty,
	output logic signed [dqd_pkg::DATA_W-1:0] entry_value,
	output logic                              last,
	output logic                              overflow
);
	import dqd_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_cmd_t                cmd;
	logic [IDX_W-1:0]         sel_idx;
	logic signed [DATA_W-1:0] cell_val [DEPTH];

	// Controller.
	dqd_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.value       (value),
		.head_val    (cell_val[0]),
		.busy        (busy),
		.cmd         (cmd),
		.sel_idx     (sel_idx),
		.strobe      (strobe),
		.is_empty    (is_empty),
		.entry_value (entry_value),
		.last        (last),
		.overflow    (overflow)
	);

	// Chain of cells; cell 0 is the front of the queue.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_v;
		logic signed [DATA_W-1:0] next_v;

		if (i == 0) begin : g_first
			assign prev_v = cmd.data;
		end else begin : g_mid_prev
			assign prev_v = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign next_v = cell_val[i];
		end else begin : g_mid_next
			assign next_v = cell_val[i+1];
		end

		dqd_cell #(
			.INDEX (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.sel_idx  (sel_idx),
			.prev_val (prev_v),
			.next_val (next_v),
			.head_val (cell_val[0]),
			.val      (cell_val[i])
		);
	end

endmodule

>>> rtl/dqd_checker.sv
// Port-level checker for the queue dump sequencing, bound to the top level.
`timescale 1ns / 1ps

module dqd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic is_empty,
	input logic last,
	input logic overflow
);

	// A taken command always starts a dump.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a command was taken");

	// Every word but the final one of a dump comes while busy is held.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("dump word shown while not busy");

	// The final word frees the block in the same cycle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high on the final word of a dump");

	// The next dump cannot follow the final word without a gap.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("word shown right after the final word of a dump");

	// An empty dump is a single word and never reports a dropped insert.
	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_empty |-> last && !overflow)
		else $error("empty dump word without last or with overflow");

endmodule

bind deque_with_contents_dump dqd_checker u_dqd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.is_empty (is_empty),
	.last     (last),
	.overflow (overflow)
);
